/* hw/rtl/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, constants and the output channel function of the RGB/HSL
// converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    typedef enum logic [1:0] {
        ACT_RGB2HSL = 2'd0,
        ACT_HSL2RGB = 2'd1,
        ACT_RELIGHT = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } max_sel_t;

    localparam logic [16:0] Q15_ONE        = 17'd32768;
    localparam logic [12:0] HUE_FULL       = 13'd5760;
    localparam logic [12:0] HUE_SECT       = 13'd960;
    localparam logic [12:0] HUE_GREEN_BASE = 13'd1920;
    localparam logic [12:0] HUE_BLUE_BASE  = 13'd3840;
    localparam int          DIV_STAGES     = 4;

    typedef struct packed {
        act_t        act;
        logic        dz;
        max_sel_t    sel;
        logic        tneg;
        logic [8:0]  s;
        logic [15:0] light;
        logic [12:0] h;
        logic [15:0] sat;
        logic [15:0] lit;
        logic [15:0] newl;
    } side_t;

    function automatic logic [7:0] chan_q(input logic [40:0] prim,
                                          input logic signed [41:0] m);
        logic signed [42:0] v;
        logic signed [47:0] v17;
        logic signed [11:0] q;
        v   = $signed({2'b00, prim}) + 43'(m);
        v17 = (48'(v) <<< 4) + 48'(v);
        q   = 12'(v17 >>> 36);
        if (v <= 0)
        begin
            chan_q = 8'd0;
        end
        else if (q > 12'sd255)
        begin
            chan_q = 8'd255;
        end
        else
        begin
            chan_q = q[7:0];
        end
    endfunction

endpackage

/* hw/rtl/rhc_div.sv */
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider; the quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module rhc_div #(
    parameter int NUM_W  = 23,
    parameter int DEN_W  = 8,
    parameter int Q_W    = 16,
    parameter int STAGES = 4
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo,
    output logic [DEN_W-1:0] rem
);

    localparam int W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam int SPS = (Q_W + STAGES - 1) / STAGES;

    logic [W-1:0]     n_reg [STAGES];
    logic [DEN_W-1:0] d_reg [STAGES];
    logic [Q_W-1:0]   q_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [W-1:0]     n_in;
        logic [DEN_W-1:0] d_in;
        logic [Q_W-1:0]   q_in;
        logic [W-1:0]     n_next;
        logic [Q_W-1:0]   q_next;

        if (s == 0)
        begin : g_first
            assign n_in = W'(num);
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[s-1];
            assign d_in = d_reg[s-1];
            assign q_in = q_reg[s-1];
        end

        always_comb
        begin
            int idx;
            n_next = n_in;
            q_next = q_in;
            for (int j = 0; j < SPS; j++)
            begin
                idx = Q_W - 1 - (s * SPS + j);
                if (idx >= 0)
                begin
                    if (n_next >= (W'(d_in) << idx))
                    begin
                        n_next = n_next - (W'(d_in) << idx);
                        q_next = q_next | (Q_W'(1) << idx);
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[s] <= n_next;
            d_reg[s] <= d_in;
            q_reg[s] <= q_next;
        end
    end

    assign quo = q_reg[STAGES-1];
    assign rem = n_reg[STAGES-1][DEN_W-1:0];

endmodule

/* hw/rtl/rgb_hsl_color_converter_unit.sv */
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter_unit
// Pixel converter between 8-bit RGB and HSL (hue 1/16 degree, Q1.15).
//
//   channel   signals                                   transfer
//   command   start, busy, action, red/green/blue_in,   start && !busy
//             hue_in, sat_in, light_in, likelihood
//   result    done, red/green/blue_out, hue_out,        done (one cycle)
//             sat_out, light_out
//
// One pixel per clock; a result is on the ports while done is high and
// transfers with it. Results pass the input registers, the four-stage
// dividers for saturation and hue, and the HSL to RGB multiply stages.
// busy stays low: results cannot be held.
// Reset clears only the valid pipeline.
// ----------------------------------------------------------------------------
module rgb_hsl_color_converter_unit
    import rhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [12:0] hue_in,
    input  logic [15:0] sat_in,
    input  logic [15:0] light_in,
    input  logic [15:0] likelihood,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [12:0] hue_out,
    output logic [15:0] sat_out,
    output logic [15:0] light_out
);

    localparam int LATENCY = DIV_STAGES + 5;

    logic [LATENCY-1:0] vld_reg;

    logic [1:0]  act0_reg;
    logic [7:0]  r0_reg, g0_reg, b0_reg;
    logic [12:0] h0_reg;
    logic [15:0] s0_reg, l0_reg, k0_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        act0_reg <= action;
        r0_reg   <= red_in;
        g0_reg   <= green_in;
        b0_reg   <= blue_in;
        h0_reg   <= hue_in;
        s0_reg   <= sat_in;
        l0_reg   <= light_in;
        k0_reg   <= likelihood;
    end

    // stage 0: extrema, divider operands, input clamps
    logic [7:0]  mx, mn, dd, tabs, den;
    logic [8:0]  ss;
    logic [16:0] est;
    logic [17:0] hnum;
    logic [22:0] snum;
    side_t       side_next;

    always_comb
    begin
        mx = r0_reg;
        mn = r0_reg;
        if (g0_reg > mx) mx = g0_reg;
        if (b0_reg > mx) mx = b0_reg;
        if (g0_reg < mn) mn = g0_reg;
        if (b0_reg < mn) mn = b0_reg;
        dd  = mx - mn;
        ss  = 9'(mx) + 9'(mn);
        den = (ss <= 9'd255) ? ss[7:0] : 8'(9'd510 - ss);
        side_next.act = act_t'(act0_reg);
        side_next.dz  = (dd == 8'd0);
        side_next.s   = ss;
        if (r0_reg == mx)
        begin
            side_next.sel  = SEL_RED;
            side_next.tneg = (g0_reg < b0_reg);
            tabs = (g0_reg < b0_reg) ? b0_reg - g0_reg : g0_reg - b0_reg;
        end
        else if (g0_reg == mx)
        begin
            side_next.sel  = SEL_GREEN;
            side_next.tneg = (b0_reg < r0_reg);
            tabs = (b0_reg < r0_reg) ? r0_reg - b0_reg : b0_reg - r0_reg;
        end
        else
        begin
            side_next.sel  = SEL_BLUE;
            side_next.tneg = (r0_reg < g0_reg);
            tabs = (r0_reg < g0_reg) ? g0_reg - r0_reg : r0_reg - g0_reg;
        end
        hnum = (18'(tabs) << 10) - (18'(tabs) << 6);
        snum = {dd, 15'd0};
        est  = (17'(ss) << 8) + 17'(ss);
        side_next.light = 16'(est[16:2]);
        side_next.h     = (h0_reg >= HUE_FULL) ? h0_reg - HUE_FULL : h0_reg;
        side_next.sat   = (17'(s0_reg) > Q15_ONE) ? Q15_ONE[15:0] : s0_reg;
        side_next.lit   = (17'(l0_reg) > Q15_ONE) ? Q15_ONE[15:0] : l0_reg;
        side_next.newl  = (17'(k0_reg) > Q15_ONE) ? 16'd0 : 16'(Q15_ONE - 17'(k0_reg));
    end

    logic [15:0] sat_q;
    logic [7:0]  sat_r;
    logic [9:0]  hue_q;
    logic [7:0]  hue_r;

    rhc_div #(.NUM_W(23), .DEN_W(8), .Q_W(16), .STAGES(DIV_STAGES)) u_sat_div (
        .clk (clk),
        .num (snum),
        .den (den),
        .quo (sat_q),
        .rem (sat_r)
    );

    rhc_div #(.NUM_W(18), .DEN_W(8), .Q_W(10), .STAGES(DIV_STAGES)) u_hue_div (
        .clk (clk),
        .num (hnum),
        .den (dd),
        .quo (hue_q),
        .rem (hue_r)
    );

    side_t       side_reg [DIV_STAGES];
    side_t       side_fix;
    logic [22:0] lx, le, lrem;

    always_comb
    begin
        side_fix = side_reg[0];
        lx   = 23'(side_reg[0].s) << 14;
        le   = (23'(side_reg[0].light) << 8) - 23'(side_reg[0].light);
        lrem = lx - le;
        if (lrem >= 23'd255)
        begin
            side_fix.light = side_reg[0].light + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        side_reg[1] <= side_fix;
        for (int i = 2; i < DIV_STAGES; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // stage 4: finish RGB to HSL, pick HSL operands
    side_t       sd;
    logic [12:0] hue_f, base;
    act_t        act5_reg;
    logic [12:0] h5_reg, h5_next, ho5_reg, ho5_next;
    logic [15:0] s5_reg, s5_next, l5_reg, l5_next;
    logic [15:0] so5_reg, so5_next, lo5_reg, lo5_next;

    assign sd = side_reg[DIV_STAGES-1];

    always_comb
    begin
        case (sd.sel)
            SEL_GREEN: base = HUE_GREEN_BASE;
            SEL_BLUE:  base = HUE_BLUE_BASE;
            default:   base = sd.tneg ? HUE_FULL : 13'd0;
        endcase
        if (sd.tneg)
        begin
            hue_f = base - 13'(hue_q) - 13'(hue_r != 8'd0);
        end
        else
        begin
            hue_f = base + 13'(hue_q);
        end
        if (sd.dz)
        begin
            hue_f = 13'd0;
        end
        ho5_next = 13'd0;
        so5_next = 16'd0;
        lo5_next = 16'd0;
        h5_next  = sd.h;
        s5_next  = sd.sat;
        l5_next  = sd.lit;
        case (sd.act)
            ACT_RGB2HSL:
            begin
                ho5_next = hue_f;
                so5_next = sd.dz ? 16'd0 : sat_q;
                lo5_next = sd.light;
            end
            ACT_RELIGHT:
            begin
                h5_next = hue_f;
                s5_next = sd.dz ? 16'd0 : sat_q;
                l5_next = sd.newl;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        act5_reg <= sd.act;
        h5_reg   <= h5_next;
        s5_reg   <= s5_next;
        l5_reg   <= l5_next;
        ho5_reg  <= ho5_next;
        so5_reg  <= so5_next;
        lo5_reg  <= lo5_next;
    end

    // stage 5: chroma product and sector
    logic [16:0] two_l, ldev;
    logic [15:0] onem;
    logic [12:0] hp;
    logic [30:0] c6_reg, c6_next;
    logic [9:0]  k6_reg, k6_next;
    logic [2:0]  sect6_reg, sect6_next;
    act_t        act6_reg;
    logic [15:0] l6_reg;
    logic [12:0] ho6_reg;
    logic [15:0] so6_reg, lo6_reg;

    always_comb
    begin
        two_l = {l5_reg, 1'b0};
        ldev  = (two_l >= Q15_ONE) ? two_l - Q15_ONE : Q15_ONE - two_l;
        onem  = 16'(Q15_ONE - ldev);
        c6_next = 31'(32'(onem) * 32'(s5_reg));
        if (h5_reg >= 13'd4800)      sect6_next = 3'd5;
        else if (h5_reg >= 13'd3840) sect6_next = 3'd4;
        else if (h5_reg >= 13'd2880) sect6_next = 3'd3;
        else if (h5_reg >= 13'd1920) sect6_next = 3'd2;
        else if (h5_reg >= HUE_SECT) sect6_next = 3'd1;
        else                         sect6_next = 3'd0;
        if (h5_reg >= HUE_BLUE_BASE)       hp = h5_reg - HUE_BLUE_BASE;
        else if (h5_reg >= HUE_GREEN_BASE) hp = h5_reg - HUE_GREEN_BASE;
        else                               hp = h5_reg;
        k6_next = (hp >= HUE_SECT) ? 10'(HUE_GREEN_BASE - hp) : hp[9:0];
    end

    always_ff @(posedge clk)
    begin
        c6_reg    <= c6_next;
        k6_reg    <= k6_next;
        sect6_reg <= sect6_next;
        act6_reg  <= act5_reg;
        l6_reg    <= l5_reg;
        ho6_reg   <= ho5_reg;
        so6_reg   <= so5_reg;
        lo6_reg   <= lo5_reg;
    end

    // stage 6: scaled primaries and offset
    logic [25:0]        l960;
    logic [39:0]        c480;
    logic [40:0]        pc7_reg, pc7_next, px7_reg, px7_next;
    logic signed [41:0] m7_reg, m7_next;
    logic [2:0]         sect7_reg;
    act_t               act7_reg;
    logic [12:0]        ho7_reg;
    logic [15:0]        so7_reg, lo7_reg;

    always_comb
    begin
        pc7_next = (41'(c6_reg) << 10) - (41'(c6_reg) << 6);
        px7_next = 41'(c6_reg) * 41'(k6_reg);
        l960     = (26'(l6_reg) << 10) - (26'(l6_reg) << 6);
        c480     = (40'(c6_reg) << 9) - (40'(c6_reg) << 5);
        m7_next  = $signed({1'b0, l960, 15'd0}) - $signed({2'b00, c480});
    end

    always_ff @(posedge clk)
    begin
        pc7_reg   <= pc7_next;
        px7_reg   <= px7_next;
        m7_reg    <= m7_next;
        sect7_reg <= sect6_reg;
        act7_reg  <= act6_reg;
        ho7_reg   <= ho6_reg;
        so7_reg   <= so6_reg;
        lo7_reg   <= lo6_reg;
    end

    // stage 7: channel select, scale and clamp
    logic [40:0] pr, pg, pb;
    logic [7:0]  r8_reg, r8_next, g8_reg, g8_next, b8_reg, b8_next;
    logic [12:0] ho8_reg;
    logic [15:0] so8_reg, lo8_reg;

    always_comb
    begin
        case (sect7_reg)
            3'd0:    begin pr = pc7_reg; pg = px7_reg; pb = '0;      end
            3'd1:    begin pr = px7_reg; pg = pc7_reg; pb = '0;      end
            3'd2:    begin pr = '0;      pg = pc7_reg; pb = px7_reg; end
            3'd3:    begin pr = '0;      pg = px7_reg; pb = pc7_reg; end
            3'd4:    begin pr = px7_reg; pg = '0;      pb = pc7_reg; end
            default: begin pr = pc7_reg; pg = '0;      pb = px7_reg; end
        endcase
        if (act7_reg == ACT_HSL2RGB || act7_reg == ACT_RELIGHT)
        begin
            r8_next = chan_q(pr, m7_reg);
            g8_next = chan_q(pg, m7_reg);
            b8_next = chan_q(pb, m7_reg);
        end
        else
        begin
            r8_next = 8'd0;
            g8_next = 8'd0;
            b8_next = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        r8_reg  <= r8_next;
        g8_reg  <= g8_next;
        b8_reg  <= b8_next;
        ho8_reg <= ho7_reg;
        so8_reg <= so7_reg;
        lo8_reg <= lo7_reg;
    end

    assign done      = vld_reg[LATENCY-1];
    assign red_out   = r8_reg;
    assign green_out = g8_reg;
    assign blue_out  = b8_reg;
    assign hue_out   = ho8_reg;
    assign sat_out   = so8_reg;
    assign light_out = lo8_reg;

`ifndef SYNTHESIS
    a_done_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching command transfer");

    a_hsl_rgb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(action, LATENCY) == ACT_RGB2HSL
        |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
        else $error("rgb fields not zero for rgb to hsl");

    a_rgb_hsl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(action, LATENCY) == ACT_HSL2RGB
                 || $past(action, LATENCY) == ACT_RELIGHT)
        |-> hue_out == 13'd0 && sat_out == 16'd0 && light_out == 16'd0)
        else $error("hsl fields not zero for rgb result");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hue_out < HUE_FULL && 17'(sat_out) <= Q15_ONE)
        else $error("hue or saturation out of range");
`endif

endmodule
